FILE: src/z_buffer_span_fill_core_assert.svh
// Assertion macros for the z-buffer span fill core.
// Used by z_buffer_span_fill_core.sv; the bodies are empty when SYNTHESIS is set.
`ifndef Z_BUFFER_SPAN_FILL_CORE_ASSERT_SVH
`define Z_BUFFER_SPAN_FILL_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ZBSF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define ZBSF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ZBSF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define ZBSF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: src/zbsf_pkg.sv
// Shared types and constants for the z-buffer span fill core.
// No dependencies; imported by zbsf_div, zbsf_fb and the top level.
`default_nettype none

package zbsf_pkg;

  // action codes (in_tuser)
  localparam logic [1:0] ACT_DRAW  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // status codes (out_tuser)
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_OFFSCREEN = 2'd1;
  localparam logic [1:0] ST_NZ_ZERO   = 2'd2;

  localparam int IN_DATA_W  = 160;
  localparam int OUT_DATA_W = 64;
  localparam int COORD_W    = 12;
  localparam int COLOR_W    = 24;
  localparam int DEPTH_W    = 24;
  localparam int CNT_W      = 9;
  localparam int FB_W       = COLOR_W + DEPTH_W;

  // plane arithmetic widths
  localparam int QW  = 38;        // numerator / quotient
  localparam int DVW = 16;        // |normal_z| and remainders
  localparam int AXW = 18;        // 16*x - plane_x
  localparam int PW  = 16 + AXW;  // product

  localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = 24'sh800000;
  localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = 24'sh7FFFFF;

  typedef struct packed {
    logic                 start;
    logic signed [QW-1:0] dividend;
    logic [DVW-1:0]       divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [QW-1:0] quot;
    logic [DVW-1:0]       rem;
  } div_rsp_t;

endpackage

`default_nettype wire

FILE: src/zbsf_div.sv
// Iterative floor divider: signed dividend by positive divisor, one bit per cycle.
// Depends on zbsf_pkg (div_req_t, div_rsp_t, widths).
`default_nettype none

module zbsf_div import zbsf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CW = $clog2(QW);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIX} dstate_t;

  dstate_t              state_r;
  logic                 neg_r;
  logic [QW-1:0]        mag_r;
  logic [DVW-1:0]       rem_r;
  logic [DVW-1:0]       dvs_r;
  logic [CW-1:0]        cnt_r;
  logic                 done_r;
  logic signed [QW-1:0] quot_r;
  logic [DVW-1:0]       remo_r;

  logic [DVW:0] trial;
  logic [DVW:0] diff;
  logic         fits;

  always_comb begin
    trial = {rem_r, mag_r[QW-1]};
    diff  = trial - {1'b0, dvs_r};
    fits  = trial >= {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        D_IDLE: begin
          if (req.start) begin
            neg_r   <= req.dividend[QW-1];
            mag_r   <= req.dividend[QW-1] ? QW'(-req.dividend) : QW'(req.dividend);
            rem_r   <= '0;
            dvs_r   <= req.divisor;
            cnt_r   <= CW'(QW - 1);
            state_r <= D_RUN;
          end
        end
        D_RUN: begin
          // restoring step: quotient bits shift in where dividend bits leave
          rem_r <= fits ? diff[DVW-1:0] : trial[DVW-1:0];
          mag_r <= {mag_r[QW-2:0], fits};
          cnt_r <= cnt_r - CW'(1);
          if (cnt_r == '0) begin
            state_r <= D_FIX;
          end
        end
        D_FIX: begin
          // turn truncated magnitude result into floor quotient, remainder >= 0
          if (neg_r && rem_r != '0) begin
            quot_r <= $signed(~mag_r);
            remo_r <= dvs_r - rem_r;
          end else if (neg_r) begin
            quot_r <= $signed(-mag_r);
            remo_r <= '0;
          end else begin
            quot_r <= $signed(mag_r);
            remo_r <= rem_r;
          end
          done_r  <= 1'b1;
          state_r <= D_IDLE;
        end
        default: begin
          state_r <= D_IDLE;
        end
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = remo_r;

endmodule

`default_nettype wire

FILE: src/zbsf_fb.sv
// Pixel store: one write port, one read port with registered read data.
// Word is {color, depth}; depends on zbsf_pkg for FB_W.
`default_nettype none

module zbsf_fb import zbsf_pkg::*; #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  logic [FB_W-1:0] wdata,
  input  logic [AW-1:0]   raddr,
  output logic [FB_W-1:0] rdata
);

  logic [FB_W-1:0] mem [DEPTH];
  logic [FB_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: src/z_buffer_span_fill_core.sv
// Z-buffer span fill core: depth/color store, per-span plane setup, span walker.
// Depends on zbsf_pkg, zbsf_div, zbsf_fb and z_buffer_span_fill_core_assert.svh.
//
// Usage:
//   Input channel (in_*): one transaction per action. in_tuser is the action
//   (draw span, read pixel, clear buffers). One result transaction on out_*
//   follows every input transaction, in order.
//   cfg_*: write of background_level, always ready; take effect at the next clear.
//   Draw: two products on one multiplier, two divisions on the shared divider
//   (each a start, 38 steps, a sign fix and a handoff), then one clipped pixel
//   per cycle, reading the store one pixel ahead of the depth compare and
//   write.
//   Off-screen row, zero normal z or empty span: result with no store access.
//   Read: one registered store read. Clear: every store entry, one per cycle.
//   Reset: a clearing pass over all SCREEN_SIZE*SCREEN_SIZE store entries
//   (65536 by default) runs first; in_tready stays low until it ends.
//   One item is in work at a time; in_tready is high only when idle. A held
//   result sits in the output register, so the next item is taken while the
//   receiver stalls; that item waits before its own result is loaded.
`default_nettype none

`include "z_buffer_span_fill_core_assert.svh"

module z_buffer_span_fill_core import zbsf_pkg::*; #(
  parameter int SCREEN_SIZE = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // pos_y[11:0], min_x[23:12], max_x[35:24], color_rgb[59:36], normal_x[75:60],
  // normal_y[91:76], normal_z[107:92], plane_x[123:108], plane_y[139:124],
  // plane_z[155:140], zero[159:156]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [1:0]            in_tuser,   // action[1:0]
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // written_count[8:0], pixel_color[32:9], pixel_depth[56:33], zero[63:57]
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]            out_tuser,  // status[1:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [7:0]            cfg_data,   // background_level
  input  logic                  cfg_valid,
  output logic                  cfg_ready
);

  localparam int CW    = $clog2(SCREEN_SIZE);
  localparam int NW    = $clog2(SCREEN_SIZE + 1);
  localparam int DEPTH = SCREEN_SIZE * SCREEN_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int ZW    = QW + 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MUL_A, S_MUL_B, S_ADD, S_DIVN_GO, S_DIVN_WAIT,
    S_DIVS_GO, S_DIVS_WAIT, S_SPAN, S_TAIL, S_RD, S_RD_WAIT, S_RESULT
  } state_t;

  state_t state_r;

  // configuration and clear sweep
  logic [7:0]    bg_r;
  logic [7:0]    clr_lvl_r;
  logic [AW-1:0] clr_addr_r;
  logic          clr_resp_r;

  // item registers
  logic [CW-1:0]        y_r;
  logic [CW-1:0]        xs_r;
  logic [NW-1:0]        rem_r;
  logic [COLOR_W-1:0]   color_r;
  logic signed [15:0]   nx_r;
  logic signed [15:0]   ny_r;
  logic signed [15:0]   px_r;
  logic signed [15:0]   py_r;
  logic signed [15:0]   pz_r;
  logic                 neg_r;
  logic [DVW-1:0]       dabs_r;

  // setup and walker
  logic signed [PW-1:0] prod_r;
  logic signed [QW-1:0] num_r;
  logic signed [QW-1:0] fq_r;
  logic [DVW-1:0]       fr_r;
  logic signed [QW-1:0] sq_r;
  logic [DVW-1:0]       sr_r;
  logic [AW-1:0]        addr_r;
  logic                 vld_p_r;
  logic [AW-1:0]        waddr_p_r;
  logic signed [DEPTH_W-1:0] z_p_r;

  // result
  logic [1:0]           res_status_r;
  logic [CNT_W-1:0]     res_count_r;
  logic [COLOR_W-1:0]   res_color_r;
  logic [DEPTH_W-1:0]   res_depth_r;
  logic                 out_valid_r;
  logic [1:0]           out_status_r;
  logic [CNT_W-1:0]     out_count_r;
  logic [COLOR_W-1:0]   out_color_r;
  logic [DEPTH_W-1:0]   out_depth_r;

  // input field view
  logic signed [COORD_W-1:0] in_y;
  logic signed [COORD_W-1:0] in_x0;
  logic signed [COORD_W-1:0] in_x1;
  logic signed [15:0]        in_nz;
  logic                      in_acc;
  logic                      y_ok;
  logic                      x0_ok;
  logic signed [COORD_W-1:0] xs_c;
  logic signed [COORD_W-1:0] xe_c;
  logic signed [COORD_W-1:0] span_len;
  logic                      span_empty;

  always_comb begin
    in_y  = $signed(in_tdata[11:0]);
    in_x0 = $signed(in_tdata[23:12]);
    in_x1 = $signed(in_tdata[35:24]);
    in_nz = $signed(in_tdata[107:92]);
    in_acc = in_tvalid && in_tready;
    y_ok  = !in_y[COORD_W-1] && ({1'b0, in_y} < 13'(SCREEN_SIZE));
    x0_ok = !in_x0[COORD_W-1] && ({1'b0, in_x0} < 13'(SCREEN_SIZE));
    xs_c  = in_x0[COORD_W-1] ? 12'sd0 : in_x0;
    if (!in_x1[COORD_W-1] && ({1'b0, in_x1} >= 13'(SCREEN_SIZE))) begin
      xe_c = COORD_W'(SCREEN_SIZE - 1);
    end else begin
      xe_c = in_x1;
    end
    span_empty = xs_c > xe_c;
    span_len   = xe_c - xs_c + 12'sd1;
  end

  // shared multiplier: nx*(16x - px), then ny*(16y - py)
  logic signed [AXW-1:0] ax;
  logic signed [AXW-1:0] ay;
  logic signed [15:0]    mul_a;
  logic signed [AXW-1:0] mul_b;
  logic signed [PW-1:0]  prod;

  always_comb begin
    ax    = $signed(AXW'({xs_r, 4'b0000})) - AXW'(px_r);
    ay    = $signed(AXW'({y_r, 4'b0000})) - AXW'(py_r);
    mul_a = (state_r == S_MUL_A) ? nx_r : ny_r;
    mul_b = (state_r == S_MUL_A) ? ax : ay;
    prod  = mul_a * mul_b;
  end

  // divider requests: sign of normal z is folded into the dividend
  div_req_t             div_req;
  div_rsp_t             div_rsp;
  logic signed [QW-1:0] step_v;
  logic signed [QW-1:0] dvd_v;

  always_comb begin
    step_v = QW'(nx_r) <<< 4;
    dvd_v  = (state_r == S_DIVN_GO) ? num_r : step_v;
    div_req.start    = (state_r == S_DIVN_GO) || (state_r == S_DIVS_GO);
    div_req.dividend = neg_r ? -dvd_v : dvd_v;
    div_req.divisor  = dabs_r;
  end

  zbsf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // per-pixel depth from floor quotient, and incremental step
  logic                      corr;
  logic signed [QW-1:0]      tq;
  logic signed [ZW-1:0]      zw;
  logic signed [DEPTH_W-1:0] zsat;
  logic [DVW:0]              fr_sum;
  logic [DVW:0]              fr_sub;
  logic                      wrap;
  logic [DVW-1:0]            fr_n;
  logic signed [QW-1:0]      fq_n;

  always_comb begin
    corr = (fr_r != '0) && fq_r[QW-1];   // floor -> toward zero for negatives
    tq   = fq_r + QW'(corr);
    zw   = ZW'(pz_r) - ZW'(tq);
    if (zw > ZW'(DEPTH_MAX)) begin
      zsat = DEPTH_MAX;
    end else if (zw < ZW'(DEPTH_MIN)) begin
      zsat = DEPTH_MIN;
    end else begin
      zsat = zw[DEPTH_W-1:0];
    end
    fr_sum = {1'b0, fr_r} + {1'b0, sr_r};
    fr_sub = fr_sum - {1'b0, dabs_r};
    wrap   = fr_sum >= {1'b0, dabs_r};
    fr_n   = wrap ? fr_sub[DVW-1:0] : fr_sum[DVW-1:0];
    fq_n   = fq_r + sq_r + QW'(wrap);
  end

  // pixel store
  logic [AW-1:0]   base_addr;
  logic            fb_we;
  logic [AW-1:0]   fb_waddr;
  logic [FB_W-1:0] fb_wdata;
  logic [AW-1:0]   fb_raddr;
  logic [FB_W-1:0] fb_rdata;
  logic            wins;

  always_comb begin
    base_addr = AW'(AW'(y_r) * AW'(SCREEN_SIZE)) + AW'(xs_r);
    wins      = z_p_r > $signed(fb_rdata[DEPTH_W-1:0]);
    fb_raddr  = (state_r == S_SPAN) ? addr_r : base_addr;
    if (state_r == S_CLEAR) begin
      fb_we    = 1'b1;
      fb_waddr = clr_addr_r;
      fb_wdata = {clr_lvl_r, clr_lvl_r, clr_lvl_r, DEPTH_MIN};
    end else begin
      fb_we    = vld_p_r && wins;
      fb_waddr = waddr_p_r;
      fb_wdata = {color_r, z_p_r};
    end
  end

  zbsf_fb #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_fb (
    .clk   (clk),
    .we    (fb_we),
    .waddr (fb_waddr),
    .wdata (fb_wdata),
    .raddr (fb_raddr),
    .rdata (fb_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      bg_r        <= '0;
      clr_lvl_r   <= '0;
      clr_addr_r  <= '0;
      clr_resp_r  <= 1'b0;
      vld_p_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        bg_r <= cfg_data;
      end
      // in S_RESULT the load below decides the valid flag
      if (out_valid_r && out_tready && state_r != S_RESULT) begin
        out_valid_r <= 1'b0;
      end
      vld_p_r <= (state_r == S_SPAN);

      // compare/write stage of the walker
      if (vld_p_r && wins && res_count_r != {CNT_W{1'b1}}) begin
        res_count_r <= res_count_r + CNT_W'(1);
      end

      case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (clr_addr_r == AW'(DEPTH - 1)) begin
            state_r <= clr_resp_r ? S_RESULT : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            res_status_r <= ST_DONE;
            res_count_r  <= '0;
            res_color_r  <= '0;
            res_depth_r  <= '0;
            y_r     <= CW'(in_y);
            xs_r    <= (in_tuser == ACT_DRAW) ? CW'(xs_c) : CW'(in_x0);
            rem_r   <= NW'(span_len);
            color_r <= in_tdata[59:36];
            nx_r    <= $signed(in_tdata[75:60]);
            ny_r    <= $signed(in_tdata[91:76]);
            px_r    <= $signed(in_tdata[123:108]);
            py_r    <= $signed(in_tdata[139:124]);
            pz_r    <= $signed(in_tdata[155:140]);
            neg_r   <= in_nz[15];
            dabs_r  <= in_nz[15] ? DVW'(-in_nz) : DVW'(in_nz);
            case (in_tuser)
              ACT_DRAW: begin
                if (!y_ok) begin
                  res_status_r <= ST_OFFSCREEN;
                  state_r      <= S_RESULT;
                end else if (in_nz == 16'sd0) begin
                  res_status_r <= ST_NZ_ZERO;
                  state_r      <= S_RESULT;
                end else if (span_empty) begin
                  state_r <= S_RESULT;
                end else begin
                  state_r <= S_MUL_A;
                end
              end
              ACT_READ: begin
                if (y_ok && x0_ok) begin
                  state_r <= S_RD;
                end else begin
                  res_status_r <= ST_OFFSCREEN;
                  state_r      <= S_RESULT;
                end
              end
              ACT_CLEAR: begin
                clr_lvl_r  <= bg_r;
                clr_addr_r <= '0;
                clr_resp_r <= 1'b1;
                state_r    <= S_CLEAR;
              end
              default: begin
                state_r <= S_RESULT;
              end
            endcase
          end
        end
        S_MUL_A: begin
          prod_r  <= prod;
          addr_r  <= base_addr;
          state_r <= S_MUL_B;
        end
        S_MUL_B: begin
          num_r   <= QW'(prod_r);
          prod_r  <= prod;
          state_r <= S_ADD;
        end
        S_ADD: begin
          num_r   <= num_r + QW'(prod_r);
          state_r <= S_DIVN_GO;
        end
        S_DIVN_GO: begin
          state_r <= S_DIVN_WAIT;
        end
        S_DIVN_WAIT: begin
          if (div_rsp.done) begin
            fq_r    <= div_rsp.quot;
            fr_r    <= div_rsp.rem;
            state_r <= S_DIVS_GO;
          end
        end
        S_DIVS_GO: begin
          state_r <= S_DIVS_WAIT;
        end
        S_DIVS_WAIT: begin
          if (div_rsp.done) begin
            sq_r    <= div_rsp.quot;
            sr_r    <= div_rsp.rem;
            state_r <= S_SPAN;
          end
        end
        S_SPAN: begin
          // read of pixel x issues now; its compare runs next cycle
          z_p_r     <= zsat;
          waddr_p_r <= addr_r;
          fq_r      <= fq_n;
          fr_r      <= fr_n;
          addr_r    <= addr_r + AW'(1);
          rem_r     <= rem_r - NW'(1);
          if (rem_r == NW'(1)) begin
            state_r <= S_TAIL;
          end
        end
        S_TAIL: begin
          state_r <= S_RESULT;
        end
        S_RD: begin
          state_r <= S_RD_WAIT;
        end
        S_RD_WAIT: begin
          res_color_r <= fb_rdata[FB_W-1:DEPTH_W];
          res_depth_r <= fb_rdata[DEPTH_W-1:0];
          state_r     <= S_RESULT;
        end
        S_RESULT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_count_r  <= res_count_r;
            out_color_r  <= res_color_r;
            out_depth_r  <= res_depth_r;
            clr_resp_r   <= 1'b0;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {7'b0, out_depth_r, out_color_r, out_count_r};

  `ZBSF_ASSERT_NOW(a_wr_in_range, clk, rst_n, fb_we, fb_waddr <= AW'(DEPTH - 1), "store write beyond screen")
  `ZBSF_ASSERT_NOW(a_rem_below_div, clk, rst_n, state_r == S_SPAN, fr_r < dabs_r, "step remainder not reduced")
  `ZBSF_ASSERT_NOW(a_div_done_waited, clk, rst_n, div_rsp.done, (state_r == S_DIVN_WAIT) || (state_r == S_DIVS_WAIT), "divider result with no waiter")
  `ZBSF_ASSERT_NEXT(a_span_tail, clk, rst_n, (state_r == S_SPAN) && (rem_r == NW'(1)), (state_r == S_TAIL) && vld_p_r, "last pixel not carried to compare stage")

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for z_buffer_span_fill_core: span draws, pixel reads, clears.
// Depends on zbsf_pkg and the core RTL; keeps its own copy of both buffers to predict results.
module testbench;
  import zbsf_pkg::*;

  localparam int SCREEN       = 256;
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int SETTLE       = 16;
  localparam int HOLD_CYCLES  = 2000;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]         action;
    logic signed [11:0] pos_y;
    logic signed [11:0] min_x;
    logic signed [11:0] max_x;
    logic [23:0]        color;
    logic signed [15:0] nx, ny, nz;
    logic signed [15:0] px, py, pz;
  } span_cmd_t;

  typedef struct {
    logic [1:0]         status;
    logic [8:0]         count;
    logic [23:0]        color;
    logic signed [23:0] depth;
  } action_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [1:0]            in_tuser;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [7:0]            cfg_data;
  logic                  cfg_valid;
  logic                  cfg_ready;

  // shadow frame: depth and color per pixel, plus the background register
  logic signed [23:0] depth_mem [SCREEN*SCREEN];
  logic [23:0]        color_mem [SCREEN*SCREEN];
  logic [7:0]         background_level;

  action_result_t pending_answers [$];
  int  mismatch_count   = 0;
  int  unexpected_count = 0;
  int  cycle_count      = 0;
  int  action_seen [4]  = '{0, 0, 0, 0};
  int  pixels_written   = 0;
  bit  idle_on          = 1'b1;
  int  stall_hold       = 0;

  z_buffer_span_fill_core #(.SCREEN_SIZE(SCREEN)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_data   (cfg_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_answers.size());
      $display("testbench: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor
  function automatic void clear_frame();
    logic [23:0] gray;
    gray = {background_level, background_level, background_level};
    for (int i = 0; i < SCREEN*SCREEN; i++) begin
      depth_mem[i] = DEPTH_MIN;
      color_mem[i] = gray;
    end
  endfunction

  function automatic logic signed [23:0] plane_depth_at(int x, int y, span_cmd_t c);
    longint num, z;
    num = longint'(c.nx) * (longint'(x) * 16 - longint'(c.px))
        + longint'(c.ny) * (longint'(y) * 16 - longint'(c.py));
    // SV signed division truncates toward zero
    z = longint'(c.pz) - num / longint'(c.nz);
    if (z > longint'(8388607)) z = 8388607;
    if (z < longint'(-8388608)) z = -8388608;
    return z[23:0];
  endfunction

  function automatic action_result_t apply_action(span_cmd_t c);
    action_result_t r;
    int lo, hi, idx;
    logic signed [23:0] d;
    r = '{status: ST_DONE, count: '0, color: '0, depth: '0};
    case (c.action)
      ACT_DRAW: begin
        if (c.pos_y < 0 || c.pos_y >= SCREEN) begin
          r.status = ST_OFFSCREEN;
        end else if (c.nz == 0) begin
          r.status = ST_NZ_ZERO;
        end else begin
          lo = (c.min_x < 0) ? 0 : int'(c.min_x);
          hi = (c.max_x > SCREEN - 1) ? SCREEN - 1 : int'(c.max_x);
          for (int x = lo; x <= hi; x++) begin
            idx = int'(c.pos_y) * SCREEN + x;
            d = plane_depth_at(x, int'(c.pos_y), c);
            if (d > depth_mem[idx]) begin
              depth_mem[idx] = d;
              color_mem[idx] = c.color;
              if (r.count < 511) r.count++;
            end
          end
        end
      end
      ACT_READ: begin
        if (c.pos_y < 0 || c.pos_y >= SCREEN || c.min_x < 0 || c.min_x >= SCREEN) begin
          r.status = ST_OFFSCREEN;
        end else begin
          idx = int'(c.pos_y) * SCREEN + int'(c.min_x);
          r.color = color_mem[idx];
          r.depth = depth_mem[idx];
        end
      end
      ACT_CLEAR: clear_frame();
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers
  function automatic span_cmd_t mk_cmd(logic [1:0] act, int y, int x0, int x1, int rgb,
                                       int nx, int ny, int nz, int px, int py, int pz);
    span_cmd_t c;
    c.action = act;
    c.pos_y  = 12'(y);
    c.min_x  = 12'(x0);
    c.max_x  = 12'(x1);
    c.color  = 24'(rgb);
    c.nx = 16'(nx);
    c.ny = 16'(ny);
    c.nz = 16'(nz);
    c.px = 16'(px);
    c.py = 16'(py);
    c.pz = 16'(pz);
    return c;
  endfunction

  function automatic span_cmd_t noise_cmd();
    span_cmd_t c;
    c.action = 2'($urandom);
    c.pos_y  = 12'($urandom);
    c.min_x  = 12'($urandom);
    c.max_x  = 12'($urandom);
    c.color  = 24'($urandom);
    c.nx = 16'($urandom);
    c.ny = 16'($urandom);
    c.nz = 16'($urandom);
    c.px = 16'($urandom);
    c.py = 16'($urandom);
    c.pz = 16'($urandom);
    return c;
  endfunction

  function automatic span_cmd_t random_cmd(bit allow_clear);
    span_cmd_t c;
    int pick, len;
    pick = $urandom_range(0, 999);
    c = noise_cmd();
    if (allow_clear && pick < 3) begin
      c.action = ACT_CLEAR;
    end else if (pick < 25) begin
      c.action = ACT_UNUSED;
    end else if (pick < 340) begin
      c.action = ACT_READ;
      if ($urandom_range(0, 4) != 0) begin
        // rows 0..7 see many overlapping spans
        c.pos_y = $urandom_range(0, 1) ? 12'($urandom_range(0, 7)) : 12'($urandom_range(0, 255));
        c.min_x = 12'($urandom_range(0, 255));
      end
    end else begin
      c.action = ACT_DRAW;
      if ($urandom_range(0, 7) != 0) begin
        c.pos_y = $urandom_range(0, 1) ? 12'($urandom_range(0, 7)) : 12'($urandom_range(0, 255));
        c.min_x = 12'(int'($urandom_range(0, 275)) - 20);
        len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 300))
                                          : int'($urandom_range(0, 40));
        if ($urandom_range(0, 19) == 0) len = -int'($urandom_range(1, 30));
        c.max_x = 12'(int'(c.min_x) + len);
        c.nx = 16'(int'($urandom_range(0, 80)) - 40);
        c.ny = 16'(int'($urandom_range(0, 80)) - 40);
        c.nz = $urandom_range(0, 1) ? 16'($urandom_range(1, 64)) : 16'($urandom);
        if ($urandom_range(0, 1)) c.nz = -c.nz;
        if ($urandom_range(0, 29) == 0) c.nz = '0;
        else if (c.nz == 0) c.nz = 16'sd1;
      end
    end
    return c;
  endfunction

  // one input transaction; valid is left high so back-to-back items need no extra edge
  task automatic send_item(input span_cmd_t c);
    action_result_t r;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tdata  <= {4'b0, c.pz, c.py, c.px, c.nz, c.ny, c.nx, c.color,
                  c.max_x, c.min_x, c.pos_y};
    in_tuser  <= c.action;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (in_tready !== 1'b1);
    r = apply_action(c);
    pending_answers.push_back(r);
    action_seen[c.action]++;
    pixels_written += r.count;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  task automatic write_background(input logic [7:0] level);
    drain_results();
    repeat (SETTLE) @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    cfg_data  <= level;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    background_level = level;
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_reset_state();
    send_item(mk_cmd(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk_cmd(ACT_READ, 255, 255, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk_cmd(ACT_READ, 77, 128, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk_cmd(ACT_READ, -1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk_cmd(ACT_READ, 0, 256, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk_cmd(ACT_READ, 2047, -2048, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk_cmd(ACT_READ, -2048, 2047, 0, 0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_span_rules();
    // row check wins over the zero-normal check
    send_item(mk_cmd(ACT_DRAW, -2048, 0, 10, 'h111111, 1, 1, 0, 0, 0, 0));
    send_item(mk_cmd(ACT_DRAW, 256, 0, 10, 'h111111, 0, 0, 1, 0, 0, 0));
    send_item(mk_cmd(ACT_DRAW, 2047, 0, 10, 'h111111, 0, 0, 1, 0, 0, 0));
    send_item(mk_cmd(ACT_DRAW, 10, 0, 10, 'h222222, 0, 0, 0, 0, 0, 0));
    // empty spans
    send_item(mk_cmd(ACT_DRAW, 10, 20, 5, 'h333333, 0, 0, 1, 0, 0, 100));
    send_item(mk_cmd(ACT_DRAW, 10, -2048, -1, 'h333333, 0, 0, 1, 0, 0, 100));
    send_item(mk_cmd(ACT_DRAW, 10, 256, 2047, 'h333333, 0, 0, 1, 0, 0, 100));
    // full row after clipping, then the same depth again: equal is not nearer
    send_item(mk_cmd(ACT_DRAW, 0, -2048, 2047, 'h123456, 0, 0, 1, 0, 0, 100));
    send_item(mk_cmd(ACT_DRAW, 0, -2048, 2047, 'h654321, 0, 0, 1, 0, 0, 100));
    // saturates high on every pixel
    send_item(mk_cmd(ACT_DRAW, 0, 0, 255, 'hFFFFFF, -32768, 0, -1, 32767, 0, 32767));
    send_item(mk_cmd(ACT_READ, 0, 5, 0, 0, 0, 0, 0, 0, 0, 0));
    // saturates low: equal to the empty depth, nothing written
    send_item(mk_cmd(ACT_DRAW, 255, 0, 255, 'h0, 32767, 32767, 1, -32768, -32768, -32768));
    send_item(mk_cmd(ACT_DRAW, 255, 0, 255, 'hA5C3F0, 3, -2, -7, 1000, -500, 0));
    send_item(mk_cmd(ACT_DRAW, 255, 100, 200, 'h0F1E2D, -3, 5, 11, 2000, 4000, 40));
    send_item(mk_cmd(ACT_READ, 255, 255, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk_cmd(ACT_READ, 255, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk_cmd(ACT_READ, 255, 150, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk_cmd(ACT_UNUSED, -1, -1, -1, 'hFFFFFF, -1, -1, -1, -1, -1, -1));
    send_item(mk_cmd(ACT_UNUSED, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk_cmd(ACT_DRAW, 128, 64, 64, 'hC0FFEE, 0, 0, -32768, 0, 0, -32768));
    send_item(mk_cmd(ACT_READ, 128, 64, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk_cmd(ACT_DRAW, 128, 64, 64, 'h000000, 0, 0, 32767, 0, 0, 32767));
    send_item(mk_cmd(ACT_READ, 128, 64, 0, 0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_background_clear();
    write_background(8'hFF);
    send_item(mk_cmd(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk_cmd(ACT_READ, 3, 7, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk_cmd(ACT_READ, 0, 5, 0, 0, 0, 0, 0, 0, 0, 0));
    // register change alone leaves the buffers as they are
    write_background(8'h3C);
    send_item(mk_cmd(ACT_READ, 3, 7, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk_cmd(ACT_DRAW, 3, 7, 7, 'h00FF00, 0, 0, 5, 0, 0, 0));
    send_item(mk_cmd(ACT_READ, 3, 7, 0, 0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_backpressure();
    drain_results();
    stall_hold = HOLD_CYCLES;
    for (int i = 0; i < 8; i++) send_item(random_cmd(1'b0));
    drain_results();
  endtask

  task automatic test_random_traffic(input int n_items, input logic [7:0] level,
                                     input bit with_idle);
    idle_on = with_idle;
    write_background(level);
    send_item(mk_cmd(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < n_items; i++) send_item(random_cmd(1'b1));
    drain_results();
  endtask

  // ---------------------------------------------------------------- result side
  initial begin : rx_ready
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_hold > 0) begin
        out_tready <= 1'b0;
        repeat (stall_hold) @(posedge clk);
        stall_hold = 0;
        out_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    action_result_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tuser;
      got.count  = out_tdata[8:0];
      got.color  = out_tdata[32:9];
      got.depth  = out_tdata[56:33];
      if (pending_answers.size() == 0) begin
        unexpected_count++;
        if (mismatch_count + unexpected_count <= 10)
          $display("unexpected result transaction: status=%0d count=%0d color=%06h depth=%0d",
                   got.status, got.count, got.color, got.depth);
      end else begin
        want = pending_answers.pop_front();
        if (got.status !== want.status || got.count !== want.count ||
            got.color !== want.color || got.depth !== want.depth) begin
          mismatch_count++;
          if (mismatch_count + unexpected_count <= 10)
            $display("mismatch @%0d: exp st=%0d cnt=%0d col=%06h dep=%0d | got st=%0d cnt=%0d %s",
                     cycle_count, want.status, want.count, want.color, want.depth,
                     got.status, got.count,
                     $sformatf("col=%06h dep=%0d", got.color, got.depth));
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= '0;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    background_level = '0;
    clear_frame();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_span_rules();
    test_background_clear();
    test_backpressure();
    test_random_traffic(450, 8'($urandom), 1'b1);
    test_random_traffic(450, 8'h00, 1'b1);
    test_random_traffic(400, 8'($urandom), 1'b0);

    drain_results();
    repeat (SETTLE) @(posedge clk);
    $display("summary: %0d draws, %0d reads, %0d clears, %0d unused-action transactions",
             action_seen[ACT_DRAW], action_seen[ACT_READ], action_seen[ACT_CLEAR],
             action_seen[ACT_UNUSED]);
    $display("summary: %0d pixels written, %0d mismatches, %0d unexpected, %0d cycles",
             pixels_written, mismatch_count, unexpected_count, cycle_count);
    if (mismatch_count == 0 && unexpected_count == 0 && pending_answers.size() == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
